### rtl/lhs_pkg.sv
// Package for the latency histogram statistics unit.
// Holds the request/result types, controller-datapath command types and the
// fixed bucket boundary table; no dependencies.
`default_nettype none
package lhs_pkg;

    localparam int NUM_BUCKETS = 109;
    localparam int IDX_W       = 7;
    localparam int VAL_W       = 64;
    localparam int BP_W        = 14;
    localparam int FRAC_OUT_W  = 8;
    localparam int THR_W       = VAL_W + BP_W;   // count * basis points
    localparam int PROD_W      = THR_W + VAL_W;  // interpolation numerator
    localparam int REM_W       = THR_W + 1;
    localparam int STEP_W      = 8;
    localparam int MODE_W      = 2;

    localparam logic [BP_W-1:0]  SCALE    = 14'd10000;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [VAL_W-1:0]  sample;
        logic [BP_W-1:0]   percent_bp;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]      bucket_hit;
        logic [VAL_W-1:0]      minimum;
        logic [VAL_W-1:0]      maximum;
        logic [VAL_W-1:0]      sample_count;
        logic [VAL_W-1:0]      sample_sum;
        logic [VAL_W-1:0]      square_sum;
        logic [VAL_W-1:0]      pct_whole;
        logic [FRAC_OUT_W-1:0] pct_fraction;
        logic [VAL_W-1:0]      mean_whole;
        logic [FRAC_OUT_W-1:0] mean_fraction;
    } res_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SQ_LO, OP_SQ_MID, OP_SEARCH, OP_ADD_RD, OP_ADD_WR,
        OP_CLEAR, OP_Q_INIT, OP_Q_RD, OP_Q_ACC, OP_Q_CMP, OP_Q_DIFF, OP_Q_MUL,
        OP_Q_DEN, OP_DIV, OP_Q_FIN, OP_Q_CLAMP, OP_M_INIT, OP_M_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic srch_done;
        logic found;
        logic k_zero;
        logic last_bucket;
        logic step_last;
        logic count_zero;
    } status_t;

    typedef logic [VAL_W-1:0] bound_arr_t [NUM_BUCKETS];

    // Build the boundary table: running value times 1.5 in double precision,
    // each entry cut to its two leading decimal digits (three when those read 100 to 109).
    function automatic bound_arr_t build_bounds();
        bound_arr_t b;
        logic [VAL_W-1:0] m, p, low, half, v, pw;
        int e, n, s;
        bit stop;
        m = 64'd1 << 52;
        e = -51;
        n = 2;
        stop = 1'b0;
        for (int i = 0; i < NUM_BUCKETS; i++)
            b[i] = '0;
        b[0] = 64'd1;
        b[1] = 64'd2;
        for (int it = 0; it < NUM_BUCKETS; it++)
        begin
            if (!stop && n < NUM_BUCKETS)
            begin
                p = m * 64'd3;
                s = (p >= (64'd1 << 54)) ? 2 : 1;
                low = p & ((64'd1 << s) - 64'd1);
                half = 64'd1 << (s - 1);
                p = p >> s;
                if (low > half || (low == half && p[0]))
                    p = p + 64'd1;
                e = e - 1 + s;
                if (p == (64'd1 << 53))
                begin
                    p = p >> 1;
                    e = e + 1;
                end
                m = p;
                if (e > 11)
                    stop = 1'b1;
                else
                begin
                    v = (e >= 0) ? (m << e) : (m >> (-e));
                    pw = 64'd1;
                    for (int j = 0; j < 24; j++)
                    begin
                        if (v / 64'd10 > 64'd10)
                        begin
                            v = v / 64'd10;
                            pw = pw * 64'd10;
                        end
                    end
                    b[n] = v * pw;
                    n = n + 1;
                end
            end
        end
        for (int i = 2; i < NUM_BUCKETS; i++)
            if (i >= n)
                b[i] = b[i-1];
        return b;
    endfunction

    localparam bound_arr_t BOUNDS = build_bounds();
    localparam logic [VAL_W-1:0] BOUND_TOP = BOUNDS[NUM_BUCKETS-1];

    // Scale a 64-bit count by 10000.
    function automatic logic [THR_W-1:0] mul_scale(input logic [VAL_W-1:0] x);
        return THR_W'(x) * THR_W'(SCALE);
    endfunction

endpackage
`default_nettype wire

### rtl/lhs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module lhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 109
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

### rtl/lhs_ctrl.sv
// Sequencer for the latency histogram statistics unit.
// Depends on lhs_pkg for the command and status types.
`default_nettype none
module lhs_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_fire,
    input  wire logic [lhs_pkg::MODE_W-1:0]   req_mode,
    input  wire logic                         out_free,
    input  wire lhs_pkg::status_t             status,
    output logic                              idle,
    output lhs_pkg::cmd_t                     cmd
);

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_SQ_LO   = 21'h000002,
        S_SQ_MID  = 21'h000004,
        S_SEARCH  = 21'h000008,
        S_ADD_RD  = 21'h000010,
        S_ADD_WR  = 21'h000020,
        S_CLEAR   = 21'h000040,
        S_Q_INIT  = 21'h000080,
        S_Q_RD    = 21'h000100,
        S_Q_ACC   = 21'h000200,
        S_Q_CMP   = 21'h000400,
        S_Q_DIFF  = 21'h000800,
        S_Q_MUL   = 21'h001000,
        S_Q_DEN   = 21'h002000,
        S_DIV_P   = 21'h004000,
        S_Q_FIN   = 21'h008000,
        S_Q_CLAMP = 21'h010000,
        S_M_INIT  = 21'h020000,
        S_DIV_M   = 21'h040000,
        S_M_FIN   = 21'h080000,
        S_DONE    = 21'h100000
    } state_t;

    state_t state_reg, state_next;

    // Advance the sequence and issue one datapath op per state
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = lhs_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd.op = lhs_pkg::OP_LOAD;
                    case (req_mode)
                        lhs_pkg::MODE_ADD:   state_next = S_SQ_LO;
                        lhs_pkg::MODE_CLEAR: state_next = S_CLEAR;
                        lhs_pkg::MODE_QUERY: state_next = S_Q_INIT;
                        default:             state_next = S_DONE;
                    endcase
                end
            end
            S_SQ_LO:
            begin
                cmd.op = lhs_pkg::OP_SQ_LO;
                state_next = S_SQ_MID;
            end
            S_SQ_MID:
            begin
                cmd.op = lhs_pkg::OP_SQ_MID;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                cmd.op = lhs_pkg::OP_SEARCH;
                if (status.srch_done)
                    state_next = S_ADD_RD;
            end
            S_ADD_RD:
            begin
                cmd.op = lhs_pkg::OP_ADD_RD;
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cmd.op = lhs_pkg::OP_ADD_WR;
                state_next = S_DONE;
            end
            S_CLEAR:
            begin
                cmd.op = lhs_pkg::OP_CLEAR;
                state_next = S_DONE;
            end
            S_Q_INIT:
            begin
                cmd.op = lhs_pkg::OP_Q_INIT;
                state_next = S_Q_RD;
            end
            S_Q_RD:
            begin
                cmd.op = lhs_pkg::OP_Q_RD;
                state_next = S_Q_ACC;
            end
            S_Q_ACC:
            begin
                cmd.op = lhs_pkg::OP_Q_ACC;
                state_next = S_Q_CMP;
            end
            S_Q_CMP:
            begin
                cmd.op = lhs_pkg::OP_Q_CMP;
                if (status.found && status.k_zero)
                    state_next = S_Q_CLAMP;
                else if (status.found)
                    state_next = S_Q_DIFF;
                else if (status.last_bucket)
                    state_next = S_M_INIT;
                else
                    state_next = S_Q_RD;
            end
            S_Q_DIFF:
            begin
                cmd.op = lhs_pkg::OP_Q_DIFF;
                state_next = S_Q_MUL;
            end
            S_Q_MUL:
            begin
                cmd.op = lhs_pkg::OP_Q_MUL;
                if (status.step_last)
                    state_next = S_Q_DEN;
            end
            S_Q_DEN:
            begin
                cmd.op = lhs_pkg::OP_Q_DEN;
                state_next = S_DIV_P;
            end
            S_DIV_P:
            begin
                cmd.op = lhs_pkg::OP_DIV;
                if (status.step_last)
                    state_next = S_Q_FIN;
            end
            S_Q_FIN:
            begin
                cmd.op = lhs_pkg::OP_Q_FIN;
                state_next = S_Q_CLAMP;
            end
            S_Q_CLAMP:
            begin
                cmd.op = lhs_pkg::OP_Q_CLAMP;
                state_next = S_M_INIT;
            end
            S_M_INIT:
            begin
                cmd.op = lhs_pkg::OP_M_INIT;
                state_next = status.count_zero ? S_DONE : S_DIV_M;
            end
            S_DIV_M:
            begin
                cmd.op = lhs_pkg::OP_DIV;
                if (status.step_last)
                    state_next = S_M_FIN;
            end
            S_M_FIN:
            begin
                cmd.op = lhs_pkg::OP_M_FIN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign idle = (state_reg == S_IDLE);

endmodule
`default_nettype wire

### rtl/lhs_dp.sv
// Datapath: statistics registers, bucket store, bucket search, serial
// multiplier and shared restoring divider. Depends on lhs_pkg and lhs_ram.
`default_nettype none
module lhs_dp #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lhs_pkg::cmd_t    cmd,
    input  wire lhs_pkg::req_t    req,
    output lhs_pkg::status_t      status,
    output lhs_pkg::res_t         result
);

    localparam int VW = lhs_pkg::VAL_W;
    localparam int TW = lhs_pkg::THR_W;
    localparam int PW = lhs_pkg::PROD_W;
    localparam int RW = lhs_pkg::REM_W;
    localparam int IW = lhs_pkg::IDX_W;
    localparam int SW = lhs_pkg::STEP_W;
    localparam int QW = VW + FRACTION_BITS;
    localparam logic [QW-1:0] FMASK = (QW'(1) << FRACTION_BITS) - QW'(1);

    logic [VW-1:0]   sample_reg, sample_next;
    logic [lhs_pkg::BP_W-1:0] bp_reg, bp_next;
    logic [VW-1:0]   min_reg, min_next, max_reg, max_next;
    logic [VW-1:0]   count_reg, count_next, sum_reg, sum_next, sumsq_reg, sumsq_next;
    logic [IW-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [VW-1:0]   sqlo_reg, sqlo_next, sqx_reg, sqx_next;
    logic [TW-1:0]   thr_reg, thr_next, diff_reg, diff_next, den_reg, den_next;
    logic [VW-1:0]   cum_reg, cum_next, k_reg, k_next;
    logic [VW-1:0]   lp_reg, lp_next, mc_reg, mc_next;
    logic [PW-1:0]   num_reg, num_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [IW-1:0]   hit_reg, hit_next;
    logic [VW-1:0]   pw_reg, pw_next, mw_reg, mw_next;
    logic [lhs_pkg::FRAC_OUT_W-1:0] pf_reg, pf_next, mf_reg, mf_next;
    logic            pnz_reg, pnz_next;
    logic [lhs_pkg::NUM_BUCKETS-1:0] valid_reg, valid_next;

    logic            ram_we;
    logic [VW-1:0]   ram_wdata, ram_rdata, stored;
    logic [IW:0]     mid_sum;
    logic [IW-1:0]   mid, lp_idx;
    logic [TW-1:0]   cum_scaled;
    logic [RW-1:0]   rem_sh;
    logic            div_ge;
    logic [VW-1:0]   q_whole, lp_bound, clamp_w;
    logic [lhs_pkg::FRAC_OUT_W-1:0] q_frac, clamp_f;
    logic            clamp_nz;

    lhs_ram #(
        .WIDTH (VW),
        .DEPTH (lhs_pkg::NUM_BUCKETS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .addr  (lo_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Shared combinational pieces
    assign stored     = valid_reg[lo_reg] ? ram_rdata : '0;
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[IW:1];
    assign lp_idx     = (lo_reg == '0) ? '0 : lo_reg - IW'(1);
    assign lp_bound   = (lo_reg == '0) ? '0 : lhs_pkg::BOUNDS[lp_idx];
    assign cum_scaled = lhs_pkg::mul_scale(cum_reg);
    assign rem_sh     = {rem_reg[RW-2:0], num_reg[PW-1]};
    assign div_ge     = rem_sh >= {1'b0, den_reg};
    assign q_whole    = VW'(q_reg >> FRACTION_BITS);
    assign q_frac     = lhs_pkg::FRAC_OUT_W'(q_reg & FMASK);
    assign ram_we     = (cmd.op == lhs_pkg::OP_ADD_WR);
    assign ram_wdata  = stored + VW'(1);

    // Clamp the percentile to [min, max]
    always_comb
    begin
        clamp_w  = pw_reg;
        clamp_f  = pf_reg;
        clamp_nz = pnz_reg;
        if (clamp_w < min_reg)
        begin
            clamp_w  = min_reg;
            clamp_f  = '0;
            clamp_nz = 1'b0;
        end
        if (clamp_w > max_reg || (clamp_w == max_reg && clamp_nz))
        begin
            clamp_w = max_reg;
            clamp_f = '0;
        end
    end

    assign status.srch_done   = (lo_reg == hi_reg);
    assign status.found       = (cum_scaled >= thr_reg);
    assign status.k_zero      = (k_reg == '0);
    assign status.last_bucket = (lo_reg == lhs_pkg::LAST_IDX);
    assign status.step_last   = (step_reg == SW'(1));
    assign status.count_zero  = (count_reg == '0);

    // Execute the op for this cycle
    always_comb
    begin
        sample_next = sample_reg;  bp_next    = bp_reg;
        min_next    = min_reg;     max_next   = max_reg;
        count_next  = count_reg;   sum_next   = sum_reg;    sumsq_next = sumsq_reg;
        lo_next     = lo_reg;      hi_next    = hi_reg;
        sqlo_next   = sqlo_reg;    sqx_next   = sqx_reg;
        thr_next    = thr_reg;     diff_next  = diff_reg;   den_next   = den_reg;
        cum_next    = cum_reg;     k_next     = k_reg;
        lp_next     = lp_reg;      mc_next    = mc_reg;
        num_next    = num_reg;     rem_next   = rem_reg;    q_next     = q_reg;
        step_next   = step_reg;    hit_next   = hit_reg;
        pw_next     = pw_reg;      pf_next    = pf_reg;     pnz_next   = pnz_reg;
        mw_next     = mw_reg;      mf_next    = mf_reg;
        valid_next  = valid_reg;
        case (cmd.op)
            lhs_pkg::OP_LOAD:
            begin
                sample_next = req.sample;
                bp_next     = req.percent_bp;
                hit_next    = '0;
                pw_next     = '0;
                pf_next     = '0;
                mw_next     = '0;
                mf_next     = '0;
            end
            lhs_pkg::OP_SQ_LO:
            begin
                sqlo_next = VW'(sample_reg[31:0]) * VW'(sample_reg[31:0]);
                lo_next   = (sample_reg >= lhs_pkg::BOUND_TOP) ? lhs_pkg::LAST_IDX : '0;
                hi_next   = lhs_pkg::LAST_IDX;
            end
            lhs_pkg::OP_SQ_MID:
                sqx_next = VW'(sample_reg[31:0]) * VW'(sample_reg[63:32]);
            lhs_pkg::OP_SEARCH:
            begin
                if (lo_reg != hi_reg)
                begin
                    if (lhs_pkg::BOUNDS[mid] >= sample_reg)
                        hi_next = mid;
                    else
                        lo_next = mid + IW'(1);
                end
            end
            lhs_pkg::OP_ADD_WR:
            begin
                valid_next[lo_reg] = 1'b1;
                hit_next   = lo_reg;
                if (sample_reg < min_reg)
                    min_next = sample_reg;
                if (sample_reg > max_reg)
                    max_next = sample_reg;
                count_next = count_reg + VW'(1);
                sum_next   = sum_reg + sample_reg;
                sumsq_next = sumsq_reg + sqlo_reg + {sqx_reg[30:0], 33'b0};
            end
            lhs_pkg::OP_CLEAR:
            begin
                valid_next = '0;
                min_next   = lhs_pkg::BOUND_TOP;
                max_next   = '0;
                count_next = '0;
                sum_next   = '0;
                sumsq_next = '0;
            end
            lhs_pkg::OP_Q_INIT:
            begin
                thr_next = TW'(count_reg) * TW'(bp_reg);
                cum_next = '0;
                lo_next  = '0;
            end
            lhs_pkg::OP_Q_ACC:
            begin
                k_next   = stored;
                cum_next = cum_reg + stored;
            end
            lhs_pkg::OP_Q_CMP:
            begin
                if (cum_scaled >= thr_reg)
                begin
                    lp_next  = lp_bound;
                    mc_next  = lhs_pkg::BOUNDS[lo_reg] - lp_bound;
                    pw_next  = lp_bound;
                    pf_next  = '0;
                    pnz_next = 1'b0;
                end
                else if (lo_reg == lhs_pkg::LAST_IDX)
                begin
                    pw_next = max_reg;
                    pf_next = '0;
                end
                else
                    lo_next = lo_reg + IW'(1);
            end
            lhs_pkg::OP_Q_DIFF:
            begin
                diff_next = thr_reg - lhs_pkg::mul_scale(cum_reg - k_reg);
                num_next  = '0;
                step_next = SW'(VW);
            end
            lhs_pkg::OP_Q_MUL:
            begin
                num_next  = (num_reg << 1) + (mc_reg[VW-1] ? PW'(diff_reg) : '0);
                mc_next   = mc_reg << 1;
                step_next = step_reg - SW'(1);
            end
            lhs_pkg::OP_Q_DEN:
            begin
                den_next  = lhs_pkg::mul_scale(k_reg);
                rem_next  = '0;
                q_next    = '0;
                step_next = SW'(PW + FRACTION_BITS);
            end
            lhs_pkg::OP_DIV:
            begin
                rem_next  = div_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                q_next    = {q_reg[QW-2:0], div_ge};
                num_next  = num_reg << 1;
                step_next = step_reg - SW'(1);
            end
            lhs_pkg::OP_Q_FIN:
            begin
                pw_next  = lp_reg + q_whole;
                pf_next  = q_frac;
                pnz_next = ((q_reg & FMASK) != '0);
            end
            lhs_pkg::OP_Q_CLAMP:
            begin
                pw_next = clamp_w;
                pf_next = clamp_f;
            end
            lhs_pkg::OP_M_INIT:
            begin
                den_next  = TW'(count_reg);
                num_next  = {sum_reg, {(PW-VW){1'b0}}};
                rem_next  = '0;
                q_next    = '0;
                step_next = SW'(VW + FRACTION_BITS);
            end
            lhs_pkg::OP_M_FIN:
            begin
                mw_next = q_whole;
                mf_next = q_frac;
            end
            default: ;
        endcase
    end

    // Hold control state and the statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            min_reg   <= lhs_pkg::BOUND_TOP;
            max_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            step_reg  <= step_next;
        end
    end

    // Hold working payload
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;  bp_reg   <= bp_next;
        sqlo_reg   <= sqlo_next;    sqx_reg  <= sqx_next;
        thr_reg    <= thr_next;     diff_reg <= diff_next;  den_reg <= den_next;
        cum_reg    <= cum_next;     k_reg    <= k_next;
        lp_reg     <= lp_next;      mc_reg   <= mc_next;
        num_reg    <= num_next;     rem_reg  <= rem_next;   q_reg   <= q_next;
        hit_reg    <= hit_next;
        pw_reg     <= pw_next;      pf_reg   <= pf_next;    pnz_reg <= pnz_next;
        mw_reg     <= mw_next;      mf_reg   <= mf_next;
    end

    assign result.bucket_hit    = hit_reg;
    assign result.minimum       = min_reg;
    assign result.maximum       = max_reg;
    assign result.sample_count  = count_reg;
    assign result.sample_sum    = sum_reg;
    assign result.square_sum    = sumsq_reg;
    assign result.pct_whole     = pw_reg;
    assign result.pct_fraction  = pf_reg;
    assign result.mean_whole    = mw_reg;
    assign result.mean_fraction = mf_reg;

endmodule
`default_nettype wire

### rtl/latency_histogram_stats_unit.sv
// Top level of the latency histogram statistics unit: sequencer, datapath
// and result register. Depends on lhs_pkg, lhs_ctrl and lhs_dp.
//
//  channel   signals                          direction  carries
//  request   req_valid / req_ready / req_data  in         mode, sample, percent_bp
//  result    res_valid / res_ready / res_data  out        one result per request
//
// An add forms the two square partial products, runs a binary search over
// the boundary table, does the counter read-modify-write and loads the
// result register; a clear resets the statistics, then loads the result.
// A query walks the buckets (read, accumulate, compare) until the count
// reaches the threshold, then runs a serial multiply and a one-bit-per-cycle
// divider (142+FRACTION_BITS steps for the percentile, 64+FRACTION_BITS for
// the mean; no mean divide on an empty store). The block then goes idle.
// Reset empties the store at once; a stalled result holds the block in its
// last state, while req_ready stays low until the result register is loaded.
`default_nettype none
module latency_histogram_stats_unit #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire lhs_pkg::req_t  req_data,
    output logic                res_valid,
    input  wire logic           res_ready,
    output lhs_pkg::res_t       res_data
);

    lhs_pkg::cmd_t    cmd;
    lhs_pkg::status_t status;
    lhs_pkg::res_t    result;
    logic             req_fire, out_free;
    logic             res_valid_reg, res_valid_next;
    lhs_pkg::res_t    res_data_reg;

    assign req_fire = req_valid && req_ready;
    assign out_free = !res_valid_reg || res_ready;

    lhs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (req_fire),
        .req_mode (req_data.mode),
        .out_free (out_free),
        .status   (status),
        .idle     (req_ready),
        .cmd      (cmd)
    );

    lhs_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req_data),
        .status (status),
        .result (result)
    );

    // Advance the result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.out_load)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            res_data_reg <= result;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // One request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("request accepted while another is in flight");

    // Never overwrite a waiting result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!res_valid || res_ready))
        else $error("result register overwritten");

    // Bucket index stays inside the table
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.bucket_hit <= lhs_pkg::LAST_IDX))
        else $error("bucket index out of range");

endmodule
`default_nettype wire

### tb/sv/latency_histogram_stats_unit_tb.sv
// Testbench for latency_histogram_stats_unit: directed and random requests
// checked against a self-contained scoreboard predictor.
// Depends on lhs_pkg for the request and result types and the mode codes.
module latency_histogram_stats_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_REQUESTS = 830;
    localparam int HOLDOFF_CYCLES = 400;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Histogram predictor: own boundary table, store and expectation queue
    class lhs_scoreboard;
        logic [63:0] edges [lhs_pkg::NUM_BUCKETS];
        logic [63:0] counts [lhs_pkg::NUM_BUCKETS];
        logic [63:0] lo_seen, hi_seen, n_seen, total, sq_total;
        lhs_pkg::res_t pending [$];
        int mismatches;
        int checked;

        function new();
            logic [63:0] m, p, low, half, v, pw;
            int e, n, s;
            m = 64'd1 << 52;
            e = -51;
            n = 2;
            edges[0] = 64'd1;
            edges[1] = 64'd2;
            while (n < lhs_pkg::NUM_BUCKETS)
            begin
                p = m * 64'd3;
                s = (p >= (64'd1 << 54)) ? 2 : 1;
                low = p & ((64'd1 << s) - 64'd1);
                half = 64'd1 << (s - 1);
                p = p >> s;
                if (low > half || (low == half && p[0]))
                    p = p + 64'd1;
                e = e - 1 + s;
                if (p == (64'd1 << 53))
                begin
                    p = p >> 1;
                    e = e + 1;
                end
                m = p;
                if (e > 11)
                    break;
                v = (e >= 0) ? (m << e) : (m >> (-e));
                pw = 64'd1;
                while (v / 64'd10 > 64'd10)
                begin
                    v = v / 64'd10;
                    pw = pw * 64'd10;
                end
                edges[n] = v * pw;
                n++;
            end
            while (n < lhs_pkg::NUM_BUCKETS)
            begin
                edges[n] = edges[n-1];
                n++;
            end
            mismatches = 0;
            checked = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (counts[i])
                counts[i] = '0;
            lo_seen = edges[lhs_pkg::NUM_BUCKETS-1];
            hi_seen = '0;
            n_seen = '0;
            total = '0;
            sq_total = '0;
        endfunction

        function int slot_of(logic [63:0] v);
            if (v >= edges[lhs_pkg::NUM_BUCKETS-1])
                return lhs_pkg::NUM_BUCKETS - 1;
            for (int i = 0; i < lhs_pkg::NUM_BUCKETS - 1; i++)
                if (edges[i] >= v)
                    return i;
            return lhs_pkg::NUM_BUCKETS - 1;
        endfunction

        // Interpolate inside the bucket where the running count crosses the threshold
        function void percentile(logic [13:0] bp, output logic [63:0] w, output logic [7:0] f);
            logic [191:0] thr, acc, num, den, quo, rem;
            logic [63:0] cum, k, lp, rp;
            cum = '0;
            thr = 192'(n_seen) * 192'(bp);
            for (int b = 0; b < lhs_pkg::NUM_BUCKETS; b++)
            begin
                k = counts[b];
                cum = cum + k;
                acc = 192'(cum) * 192'd10000;
                if (acc >= thr)
                begin
                    lp = (b == 0) ? 64'd0 : edges[b-1];
                    rp = edges[b];
                    w = lp;
                    f = '0;
                    if (k != 0)
                    begin
                        num = (thr - 192'(cum - k) * 192'd10000) * 192'(rp - lp);
                        den = 192'(k) * 192'd10000;
                        quo = num / den;
                        rem = num % den;
                        f = 8'((rem << 8) / den);
                        w = lp + quo[63:0];
                    end
                    if (w < lo_seen)
                    begin
                        w = lo_seen;
                        f = '0;
                    end
                    if (w > hi_seen || (w == hi_seen && f != 0))
                    begin
                        w = hi_seen;
                        f = '0;
                    end
                    return;
                end
            end
            w = hi_seen;
            f = '0;
        endfunction

        function void note_request(lhs_pkg::req_t r);
            lhs_pkg::res_t e;
            logic [127:0] rem;
            int idx;
            e = '0;
            if (r.mode == lhs_pkg::MODE_ADD)
            begin
                idx = slot_of(r.sample);
                e.bucket_hit = lhs_pkg::IDX_W'(idx);
                counts[idx] = counts[idx] + 64'd1;
                if (r.sample < lo_seen)
                    lo_seen = r.sample;
                if (r.sample > hi_seen)
                    hi_seen = r.sample;
                n_seen = n_seen + 64'd1;
                total = total + r.sample;
                sq_total = sq_total + r.sample * r.sample;
            end
            else if (r.mode == lhs_pkg::MODE_CLEAR)
                wipe();
            else if (r.mode == lhs_pkg::MODE_QUERY)
            begin
                percentile(r.percent_bp, e.pct_whole, e.pct_fraction);
                if (n_seen != 0)
                begin
                    e.mean_whole = total / n_seen;
                    rem = 128'(total % n_seen);
                    e.mean_fraction = 8'((rem << 8) / 128'(n_seen));
                end
            end
            e.minimum = lo_seen;
            e.maximum = hi_seen;
            e.sample_count = n_seen;
            e.sample_sum = total;
            e.square_sum = sq_total;
            pending = {pending, e};
        endfunction

        function void field(string name, logic [63:0] exp_v, logic [63:0] act_v, ref bit bad);
            if (exp_v !== act_v)
            begin
                bad = 1'b1;
                if (mismatches < 10)
                    $display("result %0d: %s expected %h got %h", checked, name, exp_v, act_v);
            end
        endfunction

        function void check_result(lhs_pkg::res_t a);
            lhs_pkg::res_t e;
            bit bad;
            bad = 1'b0;
            if (pending.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d arrived with no request waiting", checked);
                mismatches++;
                checked++;
                return;
            end
            e = pending.pop_front();
            field("bucket_hit", 64'(e.bucket_hit), 64'(a.bucket_hit), bad);
            field("minimum", e.minimum, a.minimum, bad);
            field("maximum", e.maximum, a.maximum, bad);
            field("sample_count", e.sample_count, a.sample_count, bad);
            field("sample_sum", e.sample_sum, a.sample_sum, bad);
            field("square_sum", e.square_sum, a.square_sum, bad);
            field("pct_whole", e.pct_whole, a.pct_whole, bad);
            field("pct_fraction", 64'(e.pct_fraction), 64'(a.pct_fraction), bad);
            field("mean_whole", e.mean_whole, a.mean_whole, bad);
            field("mean_fraction", 64'(e.mean_fraction), 64'(a.mean_fraction), bad);
            if (bad)
                mismatches++;
            checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    lhs_pkg::req_t req_data;
    logic res_valid;
    logic res_ready;
    lhs_pkg::res_t res_data;

    lhs_scoreboard sb;
    bit calm;
    int holdoff_asks;
    int n_add, n_query, n_clear, n_other;

    latency_histogram_stats_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data(res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, none while calm
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request and hold it until accepted
    task automatic send(logic [1:0] mode, logic [63:0] sample, logic [13:0] bp);
        int gap;
        lhs_pkg::req_t r;
        gap = gap_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        r.mode = mode;
        r.sample = sample;
        r.percent_bp = bp;
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
        case (mode)
            lhs_pkg::MODE_ADD: n_add++;
            lhs_pkg::MODE_QUERY: n_query++;
            lhs_pkg::MODE_CLEAR: n_clear++;
            default: n_other++;
        endcase
        @(negedge clk);
    endtask

    function automatic logic [63:0] pick_sample();
        int r;
        logic [63:0] b;
        r = $urandom_range(0, 99);
        b = sb.edges[$urandom_range(0, lhs_pkg::NUM_BUCKETS - 1)];
        if (r < 40)
            return 64'($urandom_range(0, 2000));
        if (r < 70)
            return b + 64'($urandom_range(0, 2)) - 64'd1;
        if (r < 85)
            return {$urandom, $urandom};
        return 64'($urandom);
    endfunction

    function automatic logic [13:0] pick_bp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 14'($urandom_range(0, 10000));
        if (r < 90)
            return ($urandom_range(0, 1) != 0) ? lhs_pkg::SCALE : 14'd0;
        return 14'($urandom_range(10001, 16383));
    endfunction

    // Stimulus
    initial
    begin
        logic [63:0] top;
        int r;
        sb = new();
        calm = 1'b0;
        holdoff_asks = 0;
        n_add = 0;
        n_query = 0;
        n_clear = 0;
        n_other = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        top = sb.edges[lhs_pkg::NUM_BUCKETS-1];

        // Directed: empty store, extremes, bucket edges, unused mode
        send(lhs_pkg::MODE_QUERY, 64'd0, 14'd5000);
        send(MODE_SPARE, {$urandom, $urandom}, 14'h3FFF);
        send(lhs_pkg::MODE_ADD, 64'd0, 14'd0);
        send(lhs_pkg::MODE_ADD, 64'd1, 14'd0);
        send(lhs_pkg::MODE_ADD, 64'd2, 14'd0);
        send(lhs_pkg::MODE_ADD, 64'd3, 14'd0);
        send(lhs_pkg::MODE_QUERY, 64'd0, 14'd0);
        send(lhs_pkg::MODE_QUERY, 64'd0, lhs_pkg::SCALE);
        send(lhs_pkg::MODE_QUERY, 64'd0, 14'h3FFF);
        send(lhs_pkg::MODE_ADD, top - 64'd1, 14'd0);
        send(lhs_pkg::MODE_ADD, top, 14'd0);
        send(lhs_pkg::MODE_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 14'h3FFF);
        send(lhs_pkg::MODE_ADD, sb.edges[50] + 64'd1, 14'd0);
        send(lhs_pkg::MODE_QUERY, 64'd0, 14'd5000);
        send(lhs_pkg::MODE_QUERY, 64'd0, 14'd9900);
        send(lhs_pkg::MODE_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 14'h3FFF);
        send(lhs_pkg::MODE_QUERY, 64'd0, 14'd5000);
        send(lhs_pkg::MODE_ADD, 64'd1000, 14'd0);
        send(lhs_pkg::MODE_QUERY, 64'd0, 14'd5000);
        send(MODE_SPARE, 64'd0, 14'd0);

        // Random: mostly adds, queries spread through, rare clears
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            calm = ((i / 100) % 4) == 3;
            if (i == 300)
                holdoff_asks++;
            r = $urandom_range(0, 99);
            if (r < 72)
                send(lhs_pkg::MODE_ADD, pick_sample(), 14'($urandom));
            else if (r < 94)
                send(lhs_pkg::MODE_QUERY, {$urandom, $urandom}, pick_bp());
            else if (r < 97)
                send(lhs_pkg::MODE_CLEAR, {$urandom, $urandom}, 14'($urandom));
            else
                send(MODE_SPARE, {$urandom, $urandom}, 14'($urandom));
        end
        req_valid <= 1'b0;

        // Drain, then let the block settle
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered %0d adds, %0d queries, %0d clears, %0d unused-mode requests;",
                 n_add, n_query, n_clear, n_other);
        $display("%0d results compared, %0d mismatching.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("latency_histogram_stats_unit_tb: PASS");
        else
            $display("latency_histogram_stats_unit_tb: FAIL");
        $finish;
    end

    // Result side: random stalls plus one long hold-off
    initial
    begin
        int stall, hold, seen;
        stall = 0;
        hold = 0;
        seen = 0;
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_asks != seen)
            begin
                seen = holdoff_asks;
                hold = HOLDOFF_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                res_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = gap_len();
            end
        end
    end

    // Check each accepted result
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_data);
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("latency_histogram_stats_unit_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/lhs_pkg.sv
rtl/lhs_ram.sv
rtl/lhs_ctrl.sv
rtl/lhs_dp.sv
rtl/latency_histogram_stats_unit.sv
tb/sv/latency_histogram_stats_unit_tb.sv
